### src/pcof_pkg.sv
// ----------------------------------------------------------------------------
// Point cloud obstacle filter package
// Shared widths, codes and bundle types of the obstacle filter.
// ----------------------------------------------------------------------------
package pcof_pkg;

    localparam int MAX_OBSTACLES = 16;
    localparam int CNT_W         = $clog2(MAX_OBSTACLES + 1);

    localparam int COORD_W  = 24;
    localparam int RAD_W    = 23;
    localparam int TRIG_W   = 17;
    localparam int CENTER_W = 26;
    localparam int RSQ_W    = 2 * RAD_W;
    localparam int KEPT_W   = 20;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_POINT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_COS_YAW  = 2'd2,
        CFG_SIN_YAW  = 2'd3
    } cfg_reg_t;

    // One point request on its way down the cell chain
    typedef struct packed {
        logic                       valid;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic                       last;
        logic                       hit;
    } token_t;

    // One obstacle in the sensor frame
    typedef struct packed {
        logic signed [CENTER_W-1:0] cx;
        logic signed [CENTER_W-1:0] cy;
        logic        [RSQ_W-1:0]    rsq;
    } entry_t;

endpackage

### src/pcof_xform.sv
// ----------------------------------------------------------------------------
// Obstacle transform unit
// Move an obstacle center into the sensor frame and square its radius.
// ----------------------------------------------------------------------------
module pcof_xform
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [pcof_pkg::COORD_W-1:0]    coord_x,
    input  logic signed [pcof_pkg::COORD_W-1:0]    coord_y,
    input  logic        [pcof_pkg::RAD_W-1:0]      radius,
    input  logic signed [pcof_pkg::COORD_W-1:0]    origin_x,
    input  logic signed [pcof_pkg::COORD_W-1:0]    origin_y,
    input  logic signed [pcof_pkg::TRIG_W-1:0]     cos_yaw,
    input  logic signed [pcof_pkg::TRIG_W-1:0]     sin_yaw,
    output logic                                   busy,
    output logic                                   wr_valid,
    output pcof_pkg::entry_t                       wr_entry
);

    localparam int DW   = pcof_pkg::COORD_W + 1;
    localparam int PW   = DW + pcof_pkg::TRIG_W;
    localparam int SW   = PW + 1;
    localparam int CW   = pcof_pkg::CENTER_W;
    localparam int FRAC = pcof_pkg::TRIG_W - 2;

    logic                              v0_reg;
    logic                              v1_reg;
    logic signed [DW-1:0]              dx_reg;
    logic signed [DW-1:0]              dy_reg;
    logic        [pcof_pkg::RAD_W-1:0] rad_reg;
    logic signed [PW-1:0]              pxc_reg;
    logic signed [PW-1:0]              pys_reg;
    logic signed [PW-1:0]              pyc_reg;
    logic signed [PW-1:0]              pxs_reg;
    logic        [pcof_pkg::RSQ_W-1:0] rsq_reg;
    logic signed [DW-1:0]              dx_next;
    logic signed [DW-1:0]              dy_next;
    logic signed [PW-1:0]              pxc_next;
    logic signed [PW-1:0]              pys_next;
    logic signed [PW-1:0]              pyc_next;
    logic signed [PW-1:0]              pxs_next;
    logic        [pcof_pkg::RSQ_W-1:0] rsq_next;

    // Round half up at the binary point, floor, then clamp to the center range
    function automatic logic signed [CW-1:0] round_sat(input logic signed [SW-1:0] s);
        logic signed [SW-1:0]      r;
        logic signed [SW-FRAC-1:0] q;
        logic signed [SW-FRAC-1:0] hi;
        logic signed [SW-FRAC-1:0] lo;
        r  = s + SW'(1 <<< (FRAC - 1));
        q  = r[SW-1:FRAC];
        hi = (SW-FRAC)'((1 <<< (CW - 1)) - 1);
        lo = -(SW-FRAC)'(1 <<< (CW - 1));
        if (q > hi)
        begin
            round_sat = hi[CW-1:0];
        end
        else if (q < lo)
        begin
            round_sat = lo[CW-1:0];
        end
        else
        begin
            round_sat = q[CW-1:0];
        end
    endfunction

    assign dx_next  = DW'(coord_x) - DW'(origin_x);
    assign dy_next  = DW'(coord_y) - DW'(origin_y);
    assign pxc_next = dx_reg * cos_yaw;
    assign pys_next = dy_reg * sin_yaw;
    assign pyc_next = dy_reg * cos_yaw;
    assign pxs_next = dx_reg * sin_yaw;
    assign rsq_next = rad_reg * rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start;
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            rad_reg <= radius;
        end
        if (v0_reg)
        begin
            pxc_reg <= pxc_next;
            pys_reg <= pys_next;
            pyc_reg <= pyc_next;
            pxs_reg <= pxs_next;
            rsq_reg <= rsq_next;
        end
    end

    assign busy         = v0_reg | v1_reg;
    assign wr_valid     = v1_reg;
    assign wr_entry.cx  = round_sat(SW'(pxc_reg) + SW'(pys_reg));
    assign wr_entry.cy  = round_sat(SW'(pyc_reg) - SW'(pxs_reg));
    assign wr_entry.rsq = rsq_reg;

endmodule

### src/pcof_cell.sv
// ----------------------------------------------------------------------------
// Obstacle cell
// Hold one obstacle and test each passing point against its box.
// ----------------------------------------------------------------------------
module pcof_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               en,
    input  logic               wr_en,
    input  pcof_pkg::entry_t   wr_entry,
    input  pcof_pkg::token_t   tok_in,
    output pcof_pkg::token_t   tok_out,
    output logic               busy
);

    localparam int DW = pcof_pkg::CENTER_W + 1;
    localparam int QW = 2 * DW;

    pcof_pkg::entry_t     ent_reg;
    pcof_pkg::token_t     tok_a_reg;
    pcof_pkg::token_t     tok_b_reg;
    pcof_pkg::token_t     tok_b_next;
    logic signed [QW-1:0] sqx_reg;
    logic signed [QW-1:0] sqy_reg;
    logic signed [QW-1:0] sqx_next;
    logic signed [QW-1:0] sqy_next;
    logic signed [DW-1:0] ddx;
    logic signed [DW-1:0] ddy;
    logic signed [QW-1:0] rsq_ext;
    logic                 inside_box;

    // Stage A: squared distances per axis
    assign ddx      = DW'(ent_reg.cx) - DW'(tok_in.x);
    assign ddy      = DW'(ent_reg.cy) - DW'(tok_in.y);
    assign sqx_next = ddx * ddx;
    assign sqy_next = ddy * ddy;

    // Stage B: strict compare against the squared radius
    assign rsq_ext    = $signed(QW'(ent_reg.rsq));
    assign inside_box = en && (sqx_reg < rsq_ext) && (sqy_reg < rsq_ext);

    always_comb
    begin
        tok_b_next     = tok_a_reg;
        tok_b_next.hit = tok_a_reg.hit | inside_box;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_a_reg <= '0;
            tok_b_reg <= '0;
        end
        else if (adv)
        begin
            tok_a_reg <= tok_in;
            tok_b_reg <= tok_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
        end
        if (wr_en)
        begin
            ent_reg <= wr_entry;
        end
    end

    assign tok_out = tok_b_reg;
    assign busy    = tok_a_reg.valid | tok_b_reg.valid;

endmodule

### src/point_cloud_obstacle_filter_top.sv
// ----------------------------------------------------------------------------
// Point cloud obstacle filter
// Drop cloud points that fall inside any loaded obstacle box.
// ----------------------------------------------------------------------------
// Points stream through a chain of MAX_OBSTACLES obstacle cells, two register
// stages per cell (square the per-axis distances, then compare against the
// squared radius), so a point request is accepted every cycle while neither
// the result stall nor an obstacle load holds the chain, and results leave in
// order through the result register. An add request waits until no point is
// in the chain, then passes through the transform unit (origin subtract, four
// 25x17 products, round and clamp) before the obstacle lands in its cell; no
// point is taken while the transform unit is busy. A clear request waits for
// the chain to drain and then empties the table. Adds past the table
// capacity and requests with the unused action code are accepted and dropped.
// A point is dropped if its z is negative or it lies strictly inside some
// obstacle box; with an empty table every point is kept. kept_total counts
// kept points of the current cloud, saturates, and restarts after a point
// flagged last_point. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module point_cloud_obstacle_filter_top
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // point / obstacle requests
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  logic [1:0]                            action,
    input  logic signed [pcof_pkg::COORD_W-1:0]   coord_x,
    input  logic signed [pcof_pkg::COORD_W-1:0]   coord_y,
    input  logic signed [pcof_pkg::COORD_W-1:0]   coord_z,
    input  logic        [pcof_pkg::RAD_W-1:0]     radius,
    input  logic                                  last_point,
    // filtered points
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic                                  keep,
    output logic signed [pcof_pkg::COORD_W-1:0]   out_x,
    output logic signed [pcof_pkg::COORD_W-1:0]   out_y,
    output logic signed [pcof_pkg::COORD_W-1:0]   out_z,
    output logic                                  end_of_cloud,
    output logic        [pcof_pkg::KEPT_W-1:0]    kept_total,
    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [pcof_pkg::COORD_W-1:0]          cfg_data
);

    localparam int N      = pcof_pkg::MAX_OBSTACLES;
    localparam int CNT_W  = pcof_pkg::CNT_W;
    localparam int KEPT_W = pcof_pkg::KEPT_W;
    localparam int TW     = pcof_pkg::TRIG_W;

    // Configuration registers
    logic signed [pcof_pkg::COORD_W-1:0] origin_x_reg;
    logic signed [pcof_pkg::COORD_W-1:0] origin_y_reg;
    logic signed [TW-1:0]                cos_yaw_reg;
    logic signed [TW-1:0]                sin_yaw_reg;

    // Table and cloud state
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [KEPT_W-1:0] kept_reg;
    logic [KEPT_W-1:0] kept_next;
    logic [KEPT_W-1:0] kept_inc;

    // Result register
    logic                                result_valid_reg;
    logic                                keep_reg;
    logic signed [pcof_pkg::COORD_W-1:0] out_x_reg;
    logic signed [pcof_pkg::COORD_W-1:0] out_y_reg;
    logic signed [pcof_pkg::COORD_W-1:0] out_z_reg;
    logic                                eoc_reg;
    logic [KEPT_W-1:0]                   kept_total_reg;

    // Chain and load control
    pcof_pkg::token_t tok [N+1];
    pcof_pkg::entry_t load_entry;
    logic [N-1:0]     cell_en;
    logic [N-1:0]     cell_wr;
    logic [N-1:0]     cell_busy;
    logic             chain_busy;
    logic             load_busy;
    logic             load_wr;
    logic             load_start;
    logic             adv;
    logic             item_acc;
    logic             point_acc;
    logic             point_keep;

    // Advance the whole chain whenever the result register can take a request
    assign adv        = !result_valid_reg || !result_stall;
    assign chain_busy = |cell_busy;

    always_comb
    begin
        unique case (action) inside
            pcof_pkg::ACT_POINT:
            begin
                item_stall = !adv || load_busy;
            end
            pcof_pkg::ACT_ADD, pcof_pkg::ACT_CLEAR:
            begin
                // hold table changes until no point is in flight
                item_stall = chain_busy || load_busy;
            end
            default:
            begin
                item_stall = 1'b0;
            end
        endcase
    end

    assign item_acc   = item_valid && !item_stall;
    assign point_acc  = item_acc && (action == pcof_pkg::ACT_POINT);
    assign load_start = item_acc && (action == pcof_pkg::ACT_ADD)
                        && (count_reg < CNT_W'(N));

    // Inject the point; a negative z drops it only when the table is not empty
    always_comb
    begin
        tok[0].valid = point_acc;
        tok[0].x     = coord_x;
        tok[0].y     = coord_y;
        tok[0].z     = coord_z;
        tok[0].last  = last_point;
        tok[0].hit   = (count_reg != '0) && coord_z[pcof_pkg::COORD_W-1];
    end

    pcof_xform u_xform
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (load_start),
        .coord_x  (coord_x),
        .coord_y  (coord_y),
        .radius   (radius),
        .origin_x (origin_x_reg),
        .origin_y (origin_y_reg),
        .cos_yaw  (cos_yaw_reg),
        .sin_yaw  (sin_yaw_reg),
        .busy     (load_busy),
        .wr_valid (load_wr),
        .wr_entry (load_entry)
    );

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        assign cell_en[k] = (count_reg > CNT_W'(k));
        assign cell_wr[k] = load_wr && (count_reg == CNT_W'(k));

        pcof_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .en       (cell_en[k]),
            .wr_en    (cell_wr[k]),
            .wr_entry (load_entry),
            .tok_in   (tok[k]),
            .tok_out  (tok[k+1]),
            .busy     (cell_busy[k])
        );
    end

    // Table fill count: clear drops it, a finished load bumps it
    always_comb
    begin
        count_next = count_reg;
        if (item_acc && (action == pcof_pkg::ACT_CLEAR))
        begin
            count_next = '0;
        end
        else if (load_wr)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // Kept counter: saturate, restart after the last point of a cloud
    assign point_keep = !tok[N].hit;
    assign kept_inc   = (point_keep && (kept_reg != '1)) ? kept_reg + KEPT_W'(1)
                                                          : kept_reg;

    always_comb
    begin
        kept_next = kept_reg;
        if (adv && tok[N].valid)
        begin
            kept_next = tok[N].last ? '0 : kept_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            cos_yaw_reg      <= TW'(32768);
            sin_yaw_reg      <= '0;
            count_reg        <= '0;
            kept_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            kept_reg  <= kept_next;
            if (adv)
            begin
                result_valid_reg <= tok[N].valid;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    pcof_pkg::CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                    pcof_pkg::CFG_ORIGIN_Y: origin_y_reg <= cfg_data;
                    pcof_pkg::CFG_COS_YAW:  cos_yaw_reg  <= cfg_data[TW-1:0];
                    pcof_pkg::CFG_SIN_YAW:  sin_yaw_reg  <= cfg_data[TW-1:0];
                    default:                origin_x_reg <= origin_x_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && tok[N].valid)
        begin
            keep_reg       <= point_keep;
            out_x_reg      <= tok[N].x;
            out_y_reg      <= tok[N].y;
            out_z_reg      <= tok[N].z;
            eoc_reg        <= tok[N].last;
            kept_total_reg <= kept_inc;
        end
    end

    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign keep         = keep_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_z        = out_z_reg;
    assign end_of_cloud = eoc_reg;
    assign kept_total   = kept_total_reg;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(N))
        else $error("obstacle count beyond table capacity");

    a_load_or_points: assert property (@(posedge clk) disable iff (!rst_n)
        !(load_busy && chain_busy))
        else $error("obstacle load overlaps points in flight");

    a_write_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        load_wr |-> !chain_busy && (count_reg < CNT_W'(N)))
        else $error("table written while points in flight or table full");

    a_kept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |=> $stable(kept_reg))
        else $error("kept counter moved while result stalled");
`endif

endmodule
